>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every clock edge outside reset
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every clock edge, reset included
`define ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/rsp_pkg.sv
`timescale 1ns / 1ps

package rsp_pkg;

  localparam int unsigned OUT_ARGS = 8;
  localparam logic [3:0] HEADER_LEN = 4'd7;
  localparam logic [15:0] TYPE_COUNT = 16'd11;
  localparam logic [3:0] TOKEN_MAX = 4'd15;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGN,
    PH_ZERO,
    PH_HEXPFX,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    RX_DEC,
    RX_OCT,
    RX_HEX
  } radix_e;

  // digit value, 16 for anything that is no digit
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    d = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = 5'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = 5'(c - 8'h41 + 8'd10);
    end
    return d;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B ||
           c == 8'h0C || c == 8'h0D;
  endfunction

  // fixed sentence header, one letter per position
  function automatic logic [7:0] header_char(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = 8'h44;
      4'd1:    ch = 8'h41;
      4'd2:    ch = 8'h4C;
      4'd3:    ch = 8'h53;
      4'd4:    ch = 8'h41;
      4'd5:    ch = 8'h49;
      4'd6:    ch = 8'h4C;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // argument count per message type
  function automatic logic [3:0] type_arg_total(input logic [3:0] t);
    logic [3:0] n;
    unique case (t)
      4'd0:    n = 4'd1;
      4'd1:    n = 4'd1;
      4'd2:    n = 4'd1;
      4'd3:    n = 4'd2;
      4'd4:    n = 4'd5;
      4'd5:    n = 4'd1;
      4'd6:    n = 4'd2;
      4'd7:    n = 4'd2;
      4'd8:    n = 4'd4;
      4'd9:    n = 4'd8;
      4'd10:   n = 4'd1;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

>>> sv/radio_sentence_parser.sv
// Radio sentence parser.
// Input channel: one ASCII character per request on char_code_i, with
// end_of_sentence_i set on the final character. Output channel: one verdict
// per sentence (verdict_o, msg_type_o, arg_a_o .. arg_h_o), rejected sentences
// report type and arguments as zero.
// Throughput: one character per cycle while no verdict is stalled, set by
// the combinational parse update between the input and result registers.
// The verdict is registered: the final character sits in the input register
// and the parse stage loads the result register from it once the output
// channel can advance.
// When the receiver stalls a waiting verdict, the parse stage holds; if the
// input register is empty, one more character is taken into it, then
// in_stall_o rises until the verdict is taken.
// Reset clears the valid flags of both channels and the parse state (the
// argument store is not reset); the block is ready for the first character of a new sentence right after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module radio_sentence_parser
  import rsp_pkg::*;
#(
  parameter int unsigned MAX_ARGS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_code_i,
  input  logic               end_of_sentence_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               verdict_o,
  output logic [3:0]         msg_type_o,
  output logic signed [31:0] arg_a_o,
  output logic signed [31:0] arg_b_o,
  output logic signed [31:0] arg_c_o,
  output logic signed [31:0] arg_d_o,
  output logic signed [31:0] arg_e_o,
  output logic signed [31:0] arg_f_o,
  output logic signed [31:0] arg_g_o,
  output logic signed [31:0] arg_h_o
);

  logic        in_valid_q;
  logic [7:0]  in_char_q;
  logic        in_eos_q;

  logic [3:0]  tok_q, tok_d;
  logic [3:0]  hpos_q, hpos_d;
  logic        hok_q, hok_d;
  phase_e      phase_q, phase_d;
  radix_e      radix_q, radix_d;
  logic        neg_q, neg_d;
  logic [31:0] acc_q, acc_d;
  logic        seen_q, seen_d;
  logic        open_q, open_d;
  logic        err_q, err_d;
  logic [15:0] type_q, type_d;
  logic [3:0]  total_q, total_d;
  logic        ended_q, ended_d;

  logic [31:0] store_q [MAX_ARGS];
  logic [MAX_ARGS-1:0] store_we;
  logic [31:0] value;

  logic        advance;
  logic        fire;
  logic        sent_ok;
  logic [3:0]  sent_total;
  logic [15:0] sent_type;
  logic [31:0] arg_val [OUT_ARGS];

  logic        out_valid_q;
  logic        out_verdict_q;
  logic [3:0]  out_type_q;
  logic [31:0] out_arg_q [OUT_ARGS];
  logic [31:0] res_arg [OUT_ARGS];

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_char_q <= char_code_i;
      in_eos_q  <= end_of_sentence_i;
    end
  end

  always_comb begin
    logic [7:0]  c;
    logic [4:0]  d;
    logic [31:0] scaled;
    logic        start_num;
    logic        auto_radix;
    logic        do_close;

    tok_d      = tok_q;
    hpos_d     = hpos_q;
    hok_d      = hok_q;
    phase_d    = phase_q;
    radix_d    = radix_q;
    neg_d      = neg_q;
    acc_d      = acc_q;
    seen_d     = seen_q;
    open_d     = open_q;
    err_d      = err_q;
    type_d     = type_q;
    total_d    = total_q;
    ended_d    = ended_q;
    store_we   = '0;
    c          = in_char_q;
    d          = digit_of(in_char_q);
    scaled     = '0;
    start_num  = 1'b0;
    auto_radix = tok_q >= 4'd2;
    do_close   = 1'b0;

    if (fire && !ended_q) begin
      if (c == 8'h00) begin
        ended_d = 1'b1;
      end else if (c == 8'h2C) begin
        do_close = open_q;
      end else begin
        if (!open_q) begin
          open_d  = 1'b1;
          hpos_d  = '0;
          phase_d = PH_LEAD;
          radix_d = RX_DEC;
          neg_d   = 1'b0;
          acc_d   = '0;
          seen_d  = 1'b0;
        end
        if (tok_q == 4'd0) begin
          if (hpos_d >= HEADER_LEN || c != header_char(hpos_d)) begin
            hok_d = 1'b0;
          end
          if (hpos_d != TOKEN_MAX) begin
            hpos_d = hpos_d + 4'd1;
          end
        end else begin
          unique case (phase_d)
            PH_LEAD: begin
              if (is_blank(c)) begin
                phase_d = PH_LEAD;
              end else if (c == 8'h2B || c == 8'h2D) begin
                neg_d   = c == 8'h2D;
                phase_d = PH_SIGN;
              end else begin
                start_num = 1'b1;
              end
            end
            PH_SIGN: begin
              start_num = 1'b1;
            end
            PH_ZERO: begin
              if (c == 8'h78 || c == 8'h58) begin
                seen_d  = 1'b0;
                radix_d = RX_HEX;
                phase_d = PH_HEXPFX;
              end else if (d < 5'd8) begin
                radix_d = RX_OCT;
                acc_d   = 32'(d);
                phase_d = PH_DIGITS;
              end else begin
                phase_d = PH_DONE;
              end
            end
            PH_HEXPFX: begin
              if (d < 5'd16) begin
                acc_d   = 32'(d);
                seen_d  = 1'b1;
                phase_d = PH_DIGITS;
              end else begin
                phase_d = PH_DONE;
              end
            end
            PH_DIGITS: begin
              priority if (radix_d == RX_OCT) begin
                scaled = {acc_d[28:0], 3'b000};
                if (d < 5'd8) acc_d = scaled + 32'(d);
                else phase_d = PH_DONE;
              end else if (radix_d == RX_HEX) begin
                scaled = {acc_d[27:0], 4'b0000};
                if (d < 5'd16) acc_d = scaled + 32'(d);
                else phase_d = PH_DONE;
              end else begin
                scaled = {acc_d[28:0], 3'b000} + {acc_d[30:0], 1'b0};
                if (d < 5'd10) acc_d = scaled + 32'(d);
                else phase_d = PH_DONE;
              end
            end
            default: begin
              phase_d = phase_d;
            end
          endcase
          if (start_num) begin
            if (d >= 5'd10) begin
              phase_d = PH_DONE;
            end else if (auto_radix && d == 5'd0) begin
              seen_d  = 1'b1;
              acc_d   = '0;
              phase_d = PH_ZERO;
            end else begin
              radix_d = RX_DEC;
              acc_d   = 32'(d);
              seen_d  = 1'b1;
              phase_d = PH_DIGITS;
            end
          end
        end
      end
    end

    if (fire && in_eos_q && open_d) begin
      do_close = 1'b1;
    end

    value = neg_d ? 32'd0 - acc_d : acc_d;

    // close the open token
    if (do_close) begin
      if (tok_d == 4'd0) begin
        if (!hok_d || hpos_d != HEADER_LEN) err_d = 1'b1;
      end else if (tok_d == 4'd1) begin
        if (!seen_d) begin
          err_d = 1'b1;
        end else begin
          type_d = value[15:0];
          if (value[15:0] >= TYPE_COUNT) err_d = 1'b1;
        end
      end else begin
        if (!seen_d || total_d >= 4'(MAX_ARGS)) begin
          err_d = 1'b1;
        end else begin
          for (int i = 0; i < MAX_ARGS; i++) begin
            if (total_d == 4'(i)) store_we[i] = 1'b1;
          end
          total_d = total_d + 4'd1;
        end
      end
      if (tok_d != TOKEN_MAX) tok_d = tok_d + 4'd1;
      open_d = 1'b0;
    end

    sent_ok = !err_d && tok_d >= 4'd2 && type_d < TYPE_COUNT &&
              total_d == type_arg_total(type_d[3:0]);
    sent_total = total_d;
    sent_type  = type_d;

    // back to a fresh sentence after the verdict
    if (fire && in_eos_q) begin
      tok_d   = '0;
      hpos_d  = '0;
      hok_d   = 1'b1;
      phase_d = PH_LEAD;
      radix_d = RX_DEC;
      neg_d   = 1'b0;
      acc_d   = '0;
      seen_d  = 1'b0;
      open_d  = 1'b0;
      err_d   = 1'b0;
      type_d  = '0;
      total_d = '0;
      ended_d = 1'b0;
    end
  end

  for (genvar g = 0; g < OUT_ARGS; g++) begin : g_arg
    if (g < MAX_ARGS) begin : g_live
      assign arg_val[g] = store_we[g] ? value : store_q[g];
    end else begin : g_none
      assign arg_val[g] = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < OUT_ARGS; i++) begin
      res_arg[i] = (sent_ok && sent_total > 4'(i)) ? arg_val[i] : 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      hpos_q  <= '0;
      hok_q   <= 1'b1;
      phase_q <= PH_LEAD;
      radix_q <= RX_DEC;
      neg_q   <= 1'b0;
      acc_q   <= '0;
      seen_q  <= 1'b0;
      open_q  <= 1'b0;
      err_q   <= 1'b0;
      type_q  <= '0;
      total_q <= '0;
      ended_q <= 1'b0;
    end else begin
      tok_q   <= tok_d;
      hpos_q  <= hpos_d;
      hok_q   <= hok_d;
      phase_q <= phase_d;
      radix_q <= radix_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
      seen_q  <= seen_d;
      open_q  <= open_d;
      err_q   <= err_d;
      type_q  <= type_d;
      total_q <= total_d;
      ended_q <= ended_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_ARGS; i++) begin
      if (store_we[i]) store_q[i] <= value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && in_eos_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_eos_q) begin
      out_verdict_q <= !sent_ok;
      out_type_q    <= sent_ok ? sent_type[3:0] : 4'd0;
      for (int i = 0; i < OUT_ARGS; i++) begin
        out_arg_q[i] <= res_arg[i];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = out_verdict_q;
  assign msg_type_o  = out_type_q;
  assign arg_a_o     = out_arg_q[0];
  assign arg_b_o     = out_arg_q[1];
  assign arg_c_o     = out_arg_q[2];
  assign arg_d_o     = out_arg_q[3];
  assign arg_e_o     = out_arg_q[4];
  assign arg_f_o     = out_arg_q[5];
  assign arg_g_o     = out_arg_q[6];
  assign arg_h_o     = out_arg_q[7];

  `ASSERT_RST(a_stall_cause, clk_i, rst_ni, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without a blocked verdict")
  `ASSERT_RST(a_fresh_sentence, clk_i, rst_ni, fire && in_eos_q |=> tok_q == 4'd0 && total_q == 4'd0 && !open_q, "sentence state not cleared after verdict")
  `ASSERT_RST(a_reject_zero, clk_i, rst_ni, out_valid_o && verdict_o |-> msg_type_o == 4'd0 && arg_a_o == 32'sd0, "rejected sentence reports data")
  `ASSERT_ALL(a_total_bound, clk_i, !rst_ni || total_q <= 4'(MAX_ARGS), "argument count beyond store depth")

endmodule
